### hdl/ctrnn_euler_step_engine_macros.svh
// ---------------------------------------------------------------------------
// ctrnn euler step engine assertion macros
// shared concurrent assertion forms, clocked on aclk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef CTRNN_EULER_STEP_ENGINE_MACROS_SVH
`define CTRNN_EULER_STEP_ENGINE_MACROS_SVH

// same-cycle implication
`define CES_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CES_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ces_pkg.sv
// ---------------------------------------------------------------------------
// ces_pkg
// shared types, constants and helpers of the ctrnn euler step engine
// ---------------------------------------------------------------------------
package ces_pkg;

    localparam int DEF_MAX_NEURONS = 16;
    localparam int DEF_MAX_SENSORS = 8;
    localparam int DEF_STATE_BOUND = 32767;
    localparam int RESULT_CAP      = 16;

    localparam int CNT_W  = 5;   // neuron counter, holds up to the result cap
    localparam int TERM_W = 7;   // term counter, holds up to 64 sensors
    localparam int ACC_W  = 40;  // accumulator, room for 128 full-scale products

    localparam logic [15:0] STEP_SIZE_RST = 16'd655;
    localparam logic [4:0]  NEURONS_RST   = 5'd16;
    localparam logic [4:0]  SENS_N_RST    = 5'd0;

    typedef enum logic [3:0] {
        OP_NWEIGHT = 4'd0,
        OP_SWEIGHT = 4'd1,
        OP_BIAS    = 4'd2,
        OP_GAIN    = 4'd3,
        OP_RTAU    = 4'd4,
        OP_NSTATE  = 4'd5,
        OP_SENSOR  = 4'd6,
        OP_STEP    = 4'd7,
        OP_CLEAR   = 4'd8,
        OP_READ    = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        CFG_STEP_SIZE = 2'd0,
        CFG_NEURONS   = 2'd1,
        CFG_SENS_N    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic              wipe;
        logic              accept;
        logic              acc_clr;
        logic              issue;
        logic              issue_sens;
        logic [TERM_W-1:0] term_idx;
        logic [CNT_W-1:0]  cur_idx;
        logic              do_sat;
        logic              do_diff;
        logic              do_mulh;
        logic              do_mull;
        logic              do_sum;
        logic              do_upd;
        logic              do_siga;
        logic              load_step;
        logic              load_read;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic             wipe_done;
        logic             pipe_busy;
        logic             out_free;
        logic [CNT_W-1:0] n_eff;
        logic [4:0]       sens_n;
    } status_t;

    // 256/(1+exp(-k/8)) rounded, k = 0..64
    localparam logic [8:0] LOGISTIC_LUT [65] = '{
        9'd128, 9'd136, 9'd144, 9'd152, 9'd159, 9'd167, 9'd174, 9'd181, 9'd187,
        9'd193, 9'd199, 9'd204, 9'd209, 9'd214, 9'd218, 9'd222, 9'd225, 9'd229,
        9'd232, 9'd234, 9'd237, 9'd239, 9'd241, 9'd242, 9'd244, 9'd245, 9'd246,
        9'd248, 9'd248, 9'd249, 9'd250, 9'd251, 9'd251, 9'd252, 9'd252, 9'd253,
        9'd253, 9'd254, 9'd254, 9'd254, 9'd254, 9'd254, 9'd255, 9'd255, 9'd255,
        9'd255, 9'd255, 9'd255, 9'd255, 9'd255, 9'd256, 9'd256, 9'd256, 9'd256,
        9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256,
        9'd256, 9'd256
    };

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sh7fff_ffff);
        lo = -ACC_W'(64'sh8000_0000);
        if (x > hi) begin
            return 32'sh7fff_ffff;
        end else if (x < lo) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

endpackage

### hdl/ces_ctrl.sv
// ---------------------------------------------------------------------------
// ces_ctrl
// sequencer: item decode, per-neuron integration loop and output pass
// ---------------------------------------------------------------------------
`include "ctrnn_euler_step_engine_macros.svh"

module ces_ctrl #(
    parameter int MAX_SENSORS = ces_pkg::DEF_MAX_SENSORS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  ces_pkg::op_t     in_op,
    output logic             in_ready,
    input  ces_pkg::status_t status,
    output ces_pkg::cmd_t    cmd
);
    import ces_pkg::*;

    typedef enum logic [12:0] {
        S_WIPE  = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_MAC   = 13'b0000000000100,
        S_DRAIN = 13'b0000000001000,
        S_SAT   = 13'b0000000010000,
        S_DIFF  = 13'b0000000100000,
        S_MULH  = 13'b0000001000000,
        S_MULL  = 13'b0000010000000,
        S_SUM   = 13'b0000100000000,
        S_UPD   = 13'b0001000000000,
        S_SIGA  = 13'b0010000000000,
        S_SIGB  = 13'b0100000000000,
        S_READ  = 13'b1000000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [TERM_W-1:0]   term_reg, term_next;
    logic                sens_reg, sens_next;
    logic                accept;
    logic [CNT_W-1:0]    i_inc;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign i_inc    = CNT_W'(i_reg + CNT_W'(1));

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        term_next  = term_reg;
        sens_next  = sens_reg;
        cmd        = '0;
        cmd.accept = accept;
        cmd.cur_idx  = i_reg;
        cmd.term_idx = term_reg;
        unique case (state_reg)
            S_WIPE: begin
                cmd.wipe = 1'b1;
                if (status.wipe_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && in_op == OP_STEP) begin
                    cmd.acc_clr = 1'b1;
                    i_next      = '0;
                    term_next   = '0;
                    sens_next   = 1'b0;
                    state_next  = S_MAC;
                end else if (accept && in_op == OP_READ) begin
                    state_next = S_READ;
                end
            end
            S_MAC: begin
                cmd.issue      = 1'b1;
                cmd.issue_sens = sens_reg;
                if (!sens_reg) begin
                    if (TERM_W'(term_reg + TERM_W'(1)) == TERM_W'(status.n_eff)) begin
                        term_next = '0;
                        if (5'(i_reg) < status.sens_n) begin
                            sens_next = 1'b1;
                        end else begin
                            state_next = S_DRAIN;
                        end
                    end else begin
                        term_next = TERM_W'(term_reg + TERM_W'(1));
                    end
                end else begin
                    if (TERM_W'(term_reg + TERM_W'(1)) == TERM_W'(MAX_SENSORS)) begin
                        term_next  = '0;
                        state_next = S_DRAIN;
                    end else begin
                        term_next = TERM_W'(term_reg + TERM_W'(1));
                    end
                end
            end
            S_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = S_SAT;
                end
            end
            S_SAT: begin
                cmd.do_sat = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                cmd.do_diff = 1'b1;
                state_next  = S_MULH;
            end
            S_MULH: begin
                cmd.do_mulh = 1'b1;
                state_next  = S_MULL;
            end
            S_MULL: begin
                cmd.do_mull = 1'b1;
                state_next  = S_SUM;
            end
            S_SUM: begin
                cmd.do_sum = 1'b1;
                state_next = S_UPD;
            end
            S_UPD: begin
                cmd.do_upd = 1'b1;
                sens_next  = 1'b0;
                term_next  = '0;
                if (i_inc == status.n_eff) begin
                    i_next     = '0;
                    state_next = S_SIGA;
                end else begin
                    cmd.acc_clr = 1'b1;
                    i_next      = i_inc;
                    state_next  = S_MAC;
                end
            end
            S_SIGA: begin
                cmd.do_siga = 1'b1;
                state_next  = S_SIGB;
            end
            S_SIGB: begin
                if (status.out_free) begin
                    cmd.load_step = 1'b1;
                    cmd.last      = (i_inc == status.n_eff);
                    if (i_inc == status.n_eff) begin
                        i_next     = '0;
                        state_next = S_IDLE;
                    end else begin
                        i_next     = i_inc;
                        state_next = S_SIGA;
                    end
                end
            end
            S_READ: begin
                if (status.out_free) begin
                    cmd.load_read = 1'b1;
                    cmd.last      = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_WIPE;
            i_reg     <= '0;
            term_reg  <= '0;
            sens_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            term_reg  <= term_next;
            sens_reg  <= sens_next;
        end
    end

    `CES_ASSERT_IMP(a_load_needs_room, cmd.load_step || cmd.load_read, status.out_free, "result loaded over a pending beat")
    `CES_ASSERT_IMP(a_sat_after_drain, state_reg == S_SAT, !status.pipe_busy, "saturation while products in flight")
    `CES_ASSERT_NXT(a_upd_then_loop, state_reg == S_UPD, state_reg == S_MAC || state_reg == S_SIGA, "bad exit from state update")

endmodule

### hdl/ces_datapath.sv
// ---------------------------------------------------------------------------
// ces_datapath
// weight memories, neuron register files, mac pipeline, euler update, logistic
// ---------------------------------------------------------------------------
module ces_datapath #(
    parameter int MAX_NEURONS = ces_pkg::DEF_MAX_NEURONS,
    parameter int MAX_SENSORS = ces_pkg::DEF_MAX_SENSORS,
    parameter int STATE_BOUND = ces_pkg::DEF_STATE_BOUND
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ces_pkg::cmd_t      cmd,
    output ces_pkg::status_t   status,
    input  ces_pkg::op_t       in_op,
    input  logic [3:0]         in_target,
    input  logic [3:0]         in_source,
    input  logic signed [15:0] in_value,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         out_index,
    output logic signed [15:0] out_state,
    output logic signed [15:0] out_output,
    output logic               out_last
);
    import ces_pkg::*;

    localparam int NIW      = $clog2(MAX_NEURONS);
    localparam int SIW      = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int NWD      = MAX_NEURONS * MAX_NEURONS;
    localparam int SWD      = MAX_NEURONS * MAX_SENSORS;
    localparam int NWA      = $clog2(NWD);
    localparam int SWA      = $clog2(SWD);
    localparam int WIPE_LEN = (NWD > SWD) ? NWD : SWD;
    localparam int WCW      = $clog2(WIPE_LEN + 1);
    localparam int NCAP     = (MAX_NEURONS < RESULT_CAP) ? MAX_NEURONS : RESULT_CAP;
    localparam logic signed [34:0] BND35 = 35'(STATE_BOUND);
    localparam logic signed [16:0] BND17 = 17'(STATE_BOUND);

    // configuration
    logic [15:0] step_size_reg;
    logic [4:0]  neurons_reg;
    logic [4:0]  sens_n_reg;
    logic [4:0]  n_one;

    // stores
    logic signed [15:0] nw_mem [NWD];
    logic signed [15:0] sw_mem [SWD];
    logic signed [15:0] bias_reg  [MAX_NEURONS];
    logic signed [15:0] gain_reg  [MAX_NEURONS];
    logic signed [15:0] rtau_reg  [MAX_NEURONS];
    logic signed [15:0] state_reg [MAX_NEURONS];
    logic signed [15:0] outp_reg  [MAX_NEURONS];
    logic signed [15:0] sens_reg  [MAX_SENSORS];

    logic [WCW-1:0] wipe_cnt_reg;

    // item decode
    logic           t_in_n, s_in_n, t_in_s, s_in_s;
    logic [NIW-1:0] t_n;
    logic [SIW-1:0] t_s;
    logic [NWA-1:0] nw_waddr, nw_raddr;
    logic [SWA-1:0] sw_waddr, sw_raddr;
    logic [3:0]     item_t_reg;
    logic           item_tn_reg;

    // indices
    logic [NIW-1:0] cur_n, term_n, st_idx, op_idx;
    logic [SIW-1:0] term_s;
    logic signed [15:0] st_rd, op_rd;

    // mac pipeline
    logic               v1_reg, v2_reg, sel1_reg;
    logic signed [15:0] nw_rd_reg, sw_rd_reg, opnd_reg;
    logic signed [31:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // update chain
    logic signed [31:0] acc32_reg, diff_reg;
    logic signed [32:0] hr_reg;
    logic signed [48:0] pph_reg;
    logic signed [49:0] ppl_reg;
    logic signed [33:0] delta_reg;
    logic signed [65:0] tot;
    logic signed [33:0] dif34;
    logic signed [34:0] upd35;
    logic signed [15:0] upd_val;

    // logistic
    logic signed [32:0] p_reg;
    logic signed [16:0] sb17;
    logic [33:0]        mag;
    logic [20:0]        ix;
    logic [6:0]         lidx;
    logic [8:0]         lval;
    logic signed [16:0] o17;
    logic signed [15:0] o_val;
    logic signed [16:0] v17;
    logic signed [15:0] v_bound;

    logic out_valid_reg;

    // ---- configuration and active counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg <= STEP_SIZE_RST;
            neurons_reg   <= NEURONS_RST;
            sens_n_reg    <= SENS_N_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_STEP_SIZE: step_size_reg <= cfg_wdata;
                CFG_NEURONS:   neurons_reg   <= cfg_wdata[4:0];
                CFG_SENS_N:    sens_n_reg    <= cfg_wdata[4:0];
                default:       ;
            endcase
        end
    end

    assign n_one = (neurons_reg == 5'd0) ? 5'd1 : neurons_reg;

    assign status.n_eff     = (32'(n_one) > NCAP) ? CNT_W'(NCAP) : CNT_W'(n_one);
    assign status.sens_n    = sens_n_reg;
    assign status.wipe_done = (32'(wipe_cnt_reg) == WIPE_LEN);
    assign status.pipe_busy = v1_reg || v2_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    // ---- address decode
    assign t_in_n = 32'(in_target) < MAX_NEURONS;
    assign s_in_n = 32'(in_source) < MAX_NEURONS;
    assign t_in_s = 32'(in_target) < MAX_SENSORS;
    assign s_in_s = 32'(in_source) < MAX_SENSORS;
    assign t_n    = NIW'(in_target);
    assign t_s    = SIW'(in_target);

    assign cur_n  = NIW'(cmd.cur_idx);
    assign term_n = NIW'(cmd.term_idx);
    assign term_s = SIW'(cmd.term_idx);

    assign nw_waddr = cmd.wipe ? NWA'(wipe_cnt_reg) :
                      NWA'(32'(in_target) * MAX_NEURONS + 32'(in_source));
    assign sw_waddr = cmd.wipe ? SWA'(wipe_cnt_reg) :
                      SWA'(32'(in_target) * MAX_SENSORS + 32'(in_source));
    assign nw_raddr = NWA'(32'(cmd.cur_idx) * MAX_NEURONS + 32'(cmd.term_idx));
    assign sw_raddr = SWA'(32'(cmd.cur_idx) * MAX_SENSORS + 32'(cmd.term_idx));

    // single read port on state and output files
    assign st_idx = cmd.load_read ? NIW'(item_t_reg) : cur_n;
    assign op_idx = cmd.issue ? term_n : NIW'(item_t_reg);
    assign st_rd  = state_reg[st_idx];
    assign op_rd  = outp_reg[op_idx];

    // bounded incoming state
    assign v17     = 17'(in_value);
    assign v_bound = (v17 > BND17) ? 16'(BND17) : ((v17 < -BND17) ? 16'(-BND17) : in_value);

    // ---- reset wipe sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wipe_cnt_reg <= '0;
        end else if (cmd.wipe && !status.wipe_done) begin
            wipe_cnt_reg <= WCW'(wipe_cnt_reg + WCW'(1));
        end
    end

    // ---- weight memories
    always_ff @(posedge aclk) begin
        if (cmd.wipe) begin
            if (32'(wipe_cnt_reg) < NWD) begin
                nw_mem[nw_waddr] <= '0;
            end
        end else if (cmd.accept && in_op == OP_NWEIGHT && t_in_n && s_in_n) begin
            nw_mem[nw_waddr] <= in_value;
        end
        nw_rd_reg <= nw_mem[nw_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wipe) begin
            if (32'(wipe_cnt_reg) < SWD) begin
                sw_mem[sw_waddr] <= '0;
            end
        end else if (cmd.accept && in_op == OP_SWEIGHT && t_in_n && s_in_s) begin
            sw_mem[sw_waddr] <= in_value;
        end
        sw_rd_reg <= sw_mem[sw_raddr];
    end

    // ---- per-neuron register files
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_NEURONS; k++) begin
                bias_reg[k]  <= '0;
                gain_reg[k]  <= '0;
                rtau_reg[k]  <= '0;
                state_reg[k] <= '0;
                outp_reg[k]  <= '0;
            end
            for (int k = 0; k < MAX_SENSORS; k++) begin
                sens_reg[k] <= '0;
            end
        end else begin
            if (cmd.accept) begin
                unique case (in_op)
                    OP_BIAS:   if (t_in_n) bias_reg[t_n] <= in_value;
                    OP_GAIN:   if (t_in_n) gain_reg[t_n] <= in_value;
                    OP_RTAU:   if (t_in_n) rtau_reg[t_n] <= in_value;
                    OP_NSTATE: if (t_in_n) state_reg[t_n] <= v_bound;
                    OP_SENSOR: if (t_in_s) sens_reg[t_s] <= in_value;
                    OP_CLEAR: begin
                        for (int k = 0; k < MAX_NEURONS; k++) begin
                            state_reg[k] <= '0;
                            outp_reg[k]  <= '0;
                        end
                        for (int k = 0; k < MAX_SENSORS; k++) begin
                            sens_reg[k] <= '0;
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.do_upd) begin
                state_reg[cur_n] <= upd_val;
            end
            if (cmd.load_step) begin
                outp_reg[cur_n] <= o_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_t_reg  <= in_target;
            item_tn_reg <= t_in_n;
        end
    end

    // ---- mac pipeline: read, multiply, accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        sel1_reg <= cmd.issue_sens;
        opnd_reg <= cmd.issue_sens ? sens_reg[term_s] : op_rd;
        prod_reg <= (sel1_reg ? sw_rd_reg : nw_rd_reg) * opnd_reg;
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // ---- euler update
    assign dif34 = 34'(acc32_reg) - (34'(st_rd) <<< 8);
    assign tot   = (66'(pph_reg) <<< 16) + 66'(ppl_reg) + 66'(64'sh8000_0000);
    assign upd35 = 35'(st_rd) + 35'(delta_reg);
    assign upd_val = (upd35 > BND35) ? 16'(BND35) :
                     ((upd35 < -BND35) ? 16'(-BND35) : upd35[15:0]);

    always_ff @(posedge aclk) begin
        if (cmd.do_sat) begin
            acc32_reg <= sat32(acc_reg);
        end
        if (cmd.do_diff) begin
            diff_reg <= sat32(ACC_W'(dif34));
            hr_reg   <= $signed({1'b0, step_size_reg}) * rtau_reg[cur_n];
        end
        if (cmd.do_mulh) begin
            // upper half of the difference carries the sign
            pph_reg <= hr_reg * $signed(diff_reg[31:16]);
        end
        if (cmd.do_mull) begin
            ppl_reg <= hr_reg * $signed({1'b0, diff_reg[15:0]});
        end
        if (cmd.do_sum) begin
            delta_reg <= tot[65:32];
        end
    end

    // ---- logistic output
    assign sb17 = 17'(st_rd) + 17'(bias_reg[cur_n]);
    assign mag  = p_reg[32] ? 34'(-34'(p_reg)) : 34'(p_reg);
    assign ix   = 21'((mag + 34'd4096) >> 13);
    assign lidx = (ix > 21'd64) ? 7'd64 : 7'(ix);
    assign lval = LOGISTIC_LUT[lidx];
    assign o17  = p_reg[32] ? (17'sd256 - 17'($signed({1'b0, lval}))) :
                              17'($signed({1'b0, lval}));
    assign o_val = (o17 > BND17) ? 16'(BND17) : ((o17 < -BND17) ? 16'(-BND17) : o17[15:0]);

    always_ff @(posedge aclk) begin
        if (cmd.do_siga) begin
            p_reg <= gain_reg[cur_n] * sb17;
        end
    end

    // ---- result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_step || cmd.load_read) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_step) begin
            out_index  <= 4'(cmd.cur_idx);
            out_state  <= st_rd;
            out_output <= o_val;
            out_last   <= cmd.last;
        end else if (cmd.load_read) begin
            out_index  <= item_t_reg;
            out_state  <= item_tn_reg ? st_rd : 16'sd0;
            out_output <= item_tn_reg ? op_rd : 16'sd0;
            out_last   <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### hdl/ctrnn_euler_step_engine.sv
// a write, clear or config beat is applied as it is taken; a read passes through the read state
// and the output register; a step sums n terms per neuron, plus MAX_SENSORS for sensor neurons
// the rate is set by the single mac pipeline, one weight per cycle, 3-stage drain per neuron
// one item in flight at a time; results leave through a one-beat output register
// after reset the weight memories are wiped by a sweep over max(MAX_NEURONS^2, MAX_NEURONS*MAX_SENSORS)
// addresses, during which no input beat is taken; configuration writes are taken throughout
// ---------------------------------------------------------------------------
// ctrnn_euler_step_engine
// continuous-time recurrent network, one forward euler step per step beat
// ---------------------------------------------------------------------------
module ctrnn_euler_step_engine #(
    parameter int MAX_NEURONS = ces_pkg::DEF_MAX_NEURONS,
    parameter int MAX_SENSORS = ces_pkg::DEF_MAX_SENSORS,
    parameter int STATE_BOUND = ces_pkg::DEF_STATE_BOUND
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // target_index[3:0], source_index[7:4], value[23:8]
    input  logic [3:0]  s_tuser,   // operation[3:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // neuron_index[3:0], neuron_state[19:4],
                                   // neuron_output[35:20], zero pad[39:36]
    output logic        m_tlast
);
    import ces_pkg::*;

    cmd_t               cmd;
    status_t            status;
    op_t                in_op;
    logic [3:0]         out_index;
    logic signed [15:0] out_state;
    logic signed [15:0] out_output;

    // operation code rides in tuser
    assign in_op = op_t'(s_tuser);

    // sequencer
    ces_ctrl #(
        .MAX_SENSORS (MAX_SENSORS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (in_op),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // stores and arithmetic
    ces_datapath #(
        .MAX_NEURONS (MAX_NEURONS),
        .MAX_SENSORS (MAX_SENSORS),
        .STATE_BOUND (STATE_BOUND)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .in_op      (in_op),
        .in_target  (s_tdata[3:0]),
        .in_source  (s_tdata[7:4]),
        .in_value   (s_tdata[23:8]),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_index  (out_index),
        .out_state  (out_state),
        .out_output (out_output),
        .out_last   (m_tlast)
    );

    // result beat packing
    assign m_tdata = {4'd0, out_output, out_state, out_index};

endmodule

### verif/ctrnn_euler_step_engine_tb.sv
// ---------------------------------------------------------------------------
// ctrnn euler step engine testbench
// drives table loads, state writes, steps, clears and reads through the
// input stream, predicts every result beat and checks it field by field
// ---------------------------------------------------------------------------
module ctrnn_euler_step_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ces_pkg::*;

    localparam int NN    = 16;
    localparam int NS    = 8;
    localparam int BOUND = 32767;

    // result beat as the block reports it
    typedef struct {
        logic [3:0]         idx;
        logic signed [15:0] st;
        logic signed [15:0] outp;
        logic               last;
    } neuron_report_t;

    // one row of the directed table; chk marks a typed-in expectation
    typedef struct {
        op_t                op;
        logic [3:0]         tgt;
        logic [3:0]         src;
        logic signed [15:0] val;
        logic               chk;
        logic signed [15:0] st;
        logic signed [15:0] outp;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    // predictor state
    logic [15:0]        h_step;
    logic [4:0]         n_reg;
    logic [4:0]         sens_reg;
    logic signed [15:0] w_nn [NN*NN];
    logic signed [15:0] w_sn [NN*NS];
    logic signed [15:0] bias_m [NN];
    logic signed [15:0] gain_m [NN];
    logic signed [15:0] rtau_m [NN];
    logic signed [15:0] state_m [NN];
    logic signed [15:0] out_m [NN];
    logic signed [15:0] sens_m [NS];

    neuron_report_t expected_reports[$];
    int errors = 0;
    int beats_seen = 0;
    int items_sent = 0;
    int steps_sent = 0;
    bit stall_on = 1'b1;

    ctrnn_euler_step_engine DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #10 aclk = ~aclk;

    // logistic of q16.16 product, table written out here as a q8.8 curve
    function automatic int logistic_q88(longint p);
        int lut [65] = '{
            128, 136, 144, 152, 159, 167, 174, 181, 187, 193, 199, 204, 209,
            214, 218, 222, 225, 229, 232, 234, 237, 239, 241, 242, 244, 245,
            246, 248, 248, 249, 250, 251, 251, 252, 252, 253, 253, 254, 254,
            254, 254, 254, 255, 255, 255, 255, 255, 255, 255, 255, 256, 256,
            256, 256, 256, 256, 256, 256, 256, 256, 256, 256, 256, 256, 256};
        longint m;
        longint k;
        m = (p < 0) ? -p : p;
        k = (m + 4096) >>> 13;
        if (k > 64) k = 64;
        return (p < 0) ? 256 - lut[k] : lut[k];
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void network_reset();
        h_step = 16'd655;
        n_reg = 5'd16;
        sens_reg = 5'd0;
        foreach (w_nn[i]) w_nn[i] = '0;
        foreach (w_sn[i]) w_sn[i] = '0;
        for (int i = 0; i < NN; i++) begin
            bias_m[i] = '0; gain_m[i] = '0; rtau_m[i] = '0;
            state_m[i] = '0; out_m[i] = '0;
        end
        foreach (sens_m[i]) sens_m[i] = '0;
    endfunction

    // apply one accepted item to the network model, queue its result beats
    function automatic void predict_network(op_t op, logic [3:0] t, logic [3:0] s,
                                            logic signed [15:0] v);
        int n;
        longint acc;
        longint diff;
        longint hr;
        longint delta;
        longint p;
        neuron_report_t r;
        case (op)
            OP_NWEIGHT: w_nn[t*NN + s] = v;
            OP_SWEIGHT: if (s < NS) w_sn[t*NS + s] = v;
            OP_BIAS:    bias_m[t] = v;
            OP_GAIN:    gain_m[t] = v;
            OP_RTAU:    rtau_m[t] = v;
            OP_NSTATE:  state_m[t] = 16'(clip(v, -BOUND, BOUND));
            OP_SENSOR:  if (t < NS) sens_m[t] = v;
            OP_CLEAR: begin
                for (int i = 0; i < NN; i++) begin
                    state_m[i] = '0; out_m[i] = '0;
                end
                foreach (sens_m[i]) sens_m[i] = '0;
            end
            OP_READ: begin
                r.idx = t; r.st = state_m[t]; r.outp = out_m[t]; r.last = 1'b1;
                expected_reports.push_back(r);
            end
            OP_STEP: begin
                n = (n_reg == 0) ? 1 : ((n_reg > NN) ? NN : n_reg);
                for (int i = 0; i < n; i++) begin
                    acc = 0;
                    for (int j = 0; j < n; j++)
                        acc += longint'(w_nn[i*NN + j]) * longint'(out_m[j]);
                    if (i < sens_reg)
                        for (int j = 0; j < NS; j++)
                            acc += longint'(w_sn[i*NS + j]) * longint'(sens_m[j]);
                    acc = clip(acc, -64'sd2147483648, 64'sd2147483647);
                    diff = clip(acc - longint'(state_m[i]) * 256,
                                -64'sd2147483648, 64'sd2147483647);
                    hr = longint'({16'd0, h_step}) * longint'(rtau_m[i]);
                    // arithmetic shift is a floor, giving round half up
                    delta = (hr * diff + (64'sd1 <<< 31)) >>> 32;
                    state_m[i] = 16'(clip(longint'(state_m[i]) + delta, -BOUND, BOUND));
                end
                for (int i = 0; i < n; i++) begin
                    p = longint'(gain_m[i]) * (longint'(state_m[i]) + longint'(bias_m[i]));
                    out_m[i] = 16'(clip(logistic_q88(p), -BOUND, BOUND));
                    r.idx = 4'(i); r.st = state_m[i]; r.outp = out_m[i];
                    r.last = (i == n - 1);
                    expected_reports.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    // result monitor, sampled at the edge
    always @(posedge aclk) begin
        neuron_report_t e;
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected beat, index", m_tdata[3:0], -1);
            end else begin
                e = expected_reports.pop_front();
                if (m_tdata[3:0] !== e.idx) report_mismatch("neuron_index", m_tdata[3:0], e.idx);
                if ($signed(m_tdata[19:4]) !== e.st)
                    report_mismatch("neuron_state", $signed(m_tdata[19:4]), e.st);
                if ($signed(m_tdata[35:20]) !== e.outp)
                    report_mismatch("neuron_output", $signed(m_tdata[35:20]), e.outp);
                if (m_tlast !== e.last) report_mismatch("last", m_tlast, e.last);
            end
        end
    end

    // receiver back-pressure on its own pattern, with a quiet stretch allowed
    always @(posedge aclk) begin
        if (!stall_on) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // one register write; the strobe drops before the next one
    task automatic write_register(cfg_idx_t idx, logic [15:0] val);
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_STEP_SIZE: h_step = val;
            CFG_NEURONS:   n_reg = val[4:0];
            CFG_SENS_N:    sens_reg = val[4:0];
            default:       ;
        endcase
    endtask

    // wait for every expected beat, then a quiet margin before config writes
    task automatic wait_drained();
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // one beat into the block; a burst leaves tvalid high between items
    task automatic send_item(op_t op, logic [3:0] t, logic [3:0] s,
                             logic signed [15:0] v, bit hold);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {v, s, t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_network(op, t, s, v);
        items_sent++;
        if (op == OP_STEP) steps_sent++;
        if (!hold) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // random item, mostly well-formed loads with steps and reads mixed in
    task automatic send_random(bit hold);
        int pick;
        logic [3:0] opc;
        logic signed [15:0] v;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: v = 16'($urandom);
            1: v = 16'($signed($urandom_range(0, 1023)) - 512);
            2: v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: v = 16'($signed($urandom_range(0, 127)) - 64);
        endcase
        if (pick < 20) opc = OP_NWEIGHT;
        else if (pick < 28) opc = OP_SWEIGHT;
        else if (pick < 33) opc = OP_BIAS;
        else if (pick < 38) opc = OP_GAIN;
        else if (pick < 44) opc = OP_RTAU;
        else if (pick < 50) opc = OP_NSTATE;
        else if (pick < 56) opc = OP_SENSOR;
        else if (pick < 74) opc = OP_STEP;
        else if (pick < 77) opc = OP_CLEAR;
        else if (pick < 94) opc = OP_READ;
        else opc = 4'($urandom_range(10, 15));
        send_item(op_t'(opc), 4'($urandom), 4'($urandom), v, hold);
    endtask

    stim_row_t directed[] = '{
        // fresh network reads all zero
        '{OP_READ,    4'd0,  4'd0, 16'sd0,      1'b1, 16'sd0,      16'sd0},
        '{OP_READ,    4'd15, 4'd0, 16'sd0,      1'b1, 16'sd0,      16'sd0},
        // written state saturates at the bound
        '{OP_NSTATE,  4'd3,  4'd0, 16'sh8000,   1'b0, 16'sd0,      16'sd0},
        '{OP_READ,    4'd3,  4'd0, 16'sd0,      1'b1, -16'sd32767, 16'sd0},
        '{OP_NSTATE,  4'd15, 4'd0, 16'sh7fff,   1'b0, 16'sd0,      16'sd0},
        '{OP_READ,    4'd15, 4'd0, 16'sd0,      1'b1, 16'sd32767,  16'sd0},
        // sensors beyond the eighth are ignored
        '{OP_SENSOR,  4'd15, 4'd0, 16'sh7fff,   1'b0, 16'sd0,      16'sd0},
        '{OP_SENSOR,  4'd7,  4'd0, 16'sh8000,   1'b0, 16'sd0,      16'sd0},
        '{OP_SWEIGHT, 4'd0,  4'd15, 16'sh7fff,  1'b0, 16'sd0,      16'sd0},
        '{OP_SWEIGHT, 4'd0,  4'd7,  16'sh8000,  1'b0, 16'sd0,      16'sd0},
        '{OP_NWEIGHT, 4'd15, 4'd15, 16'sh7fff,  1'b0, 16'sd0,      16'sd0},
        '{OP_NWEIGHT, 4'd0,  4'd15, 16'sh8000,  1'b0, 16'sd0,      16'sd0},
        '{OP_BIAS,    4'd0,  4'd0, 16'sh7fff,   1'b0, 16'sd0,      16'sd0},
        '{OP_GAIN,    4'd0,  4'd0, 16'sh8000,   1'b0, 16'sd0,      16'sd0},
        '{OP_GAIN,    4'd15, 4'd0, 16'sd256,    1'b0, 16'sd0,      16'sd0},
        '{OP_RTAU,    4'd3,  4'd0, 16'sh7fff,   1'b0, 16'sd0,      16'sd0},
        '{OP_RTAU,    4'd15, 4'd0, 16'sh8000,   1'b0, 16'sd0,      16'sd0},
        '{OP_STEP,    4'd0,  4'd0, 16'sd0,      1'b0, 16'sd0,      16'sd0},
        '{op_t'(4'd12), 4'd1, 4'd2, 16'sd5,     1'b0, 16'sd0,      16'sd0},
        '{op_t'(4'd15), 4'hf, 4'hf, 16'shffff,  1'b0, 16'sd0,      16'sd0},
        '{OP_STEP,    4'd0,  4'd0, 16'sd0,      1'b0, 16'sd0,      16'sd0},
        // clear wipes states and outputs
        '{OP_CLEAR,   4'd0,  4'd0, 16'sd0,      1'b0, 16'sd0,      16'sd0},
        '{OP_READ,    4'd15, 4'd0, 16'sd0,      1'b1, 16'sd0,      16'sd0},
        '{OP_STEP,    4'd0,  4'd0, 16'sd0,      1'b0, 16'sd0,      16'sd0}
    };

    initial begin
        neuron_report_t r;
        network_reset();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, paced one item at a time
        foreach (directed[k]) begin
            if (directed[k].chk) begin
                r.idx = directed[k].tgt; r.st = directed[k].st;
                r.outp = directed[k].outp; r.last = 1'b1;
                // typed-in value must agree with the model before it is trusted
                if (r.st !== state_m[r.idx] || r.outp !== out_m[r.idx])
                    report_mismatch("table row", k, -1);
            end
            send_item(directed[k].op, directed[k].tgt, directed[k].src,
                      directed[k].val, 1'b0);
        end

        // random phases across register settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    write_register(CFG_STEP_SIZE, 16'hffff);
                    write_register(CFG_NEURONS, 5'd1);
                    write_register(CFG_SENS_N, 5'd16);
                end
                1: begin
                    write_register(CFG_STEP_SIZE, 16'd0);
                    write_register(CFG_NEURONS, 5'd0);
                    write_register(CFG_SENS_N, 5'd0);
                end
                2: begin
                    write_register(CFG_STEP_SIZE, 16'd8192);
                    write_register(CFG_NEURONS, 5'd31);
                    write_register(CFG_SENS_N, 5'd31);
                end
                default: begin
                    write_register(CFG_STEP_SIZE, 16'($urandom));
                    write_register(CFG_NEURONS, 5'($urandom));
                    write_register(CFG_SENS_N, 5'($urandom));
                end
            endcase
            stall_on = (ph != 3);
            for (int b = 0; b < 9; b++) begin
                int len;
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) send_random(k != len - 1);
            end
        end

        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("covered %0d items, %0d steps, %0d result beats checked",
                 items_sent, steps_sent, beats_seen);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #20ms;
        $display("timeout waiting for result beats");
        $display("Test completed with failures");
        $finish;
    end

endmodule
